FILE: sv/sird_pkg.sv
// shared types and constants for the signed integer to radix digits core
`default_nettype none

package sird_pkg;

   // field and register widths
   localparam int VALUE_W      = 32;
   localparam int CHAR_W       = 8;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int RADIX_REG_W  = 5;
   localparam int SYM_PER_WORD = 8;
   localparam int DIGIT_DEPTH  = 32;
   localparam int DIGIT_IDX_W  = 5;
   localparam int DIGIT_CNT_W  = 6;
   localparam int BIT_CNT_W    = 5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIX_COUNT  = 2'd2;

   // character codes used by the alphabet check and the sign
   localparam logic [CHAR_W-1:0] SPACE_LIMIT = 8'd32;
   localparam logic [CHAR_W-1:0] DEL_CODE    = 8'd127;
   localparam logic [CHAR_W-1:0] PLUS_CODE   = 8'h2B;
   localparam logic [CHAR_W-1:0] MINUS_CODE  = 8'h2D;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic check_step;
      logic div_step;
      logic emit_sign;
      logic emit_digit;
   } sird_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic radix_bad;
      logic check_bad;
      logic check_last;
      logic conv_done;
      logic negative;
      logic last_digit;
   } sird_status_type;

endpackage

`default_nettype wire

FILE: sv/sird_datapath.sv
// datapath: alphabet registers and check, bit-serial divider, digit buffer, output register
`default_nettype none

module sird_datapath #(
   parameter int MAX_SYMBOLS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [sird_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sird_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic signed [sird_pkg::VALUE_W-1:0] req_value,
   input  wire sird_pkg::sird_cmd_type           cmd,
   output sird_pkg::sird_status_type             status,
   output logic                                  rsp_valid,
   output logic [sird_pkg::CHAR_W-1:0]           rsp_out_char,
   output logic                                  rsp_last
);
   import sird_pkg::*;

   localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
   localparam int CMP_W   = DIGIT_W + 1;

   // configuration registers
   logic [CSR_DATA_W-1:0]  sym_low_ff, sym_high_ff;
   logic [RADIX_REG_W-1:0] radix_count_ff;

   // conversion state
   logic                   neg_ff, neg_in;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_CNT_W-1:0] nd_ff, nd_in;
   logic [DIGIT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [DIGIT_W-1:0]     digits_ff [DIGIT_DEPTH];
   logic [DIGIT_W-1:0]     digit_in;
   logic                   digit_we;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic [CHAR_W-1:0]      sym [MAX_SYMBOLS];
   logic [CHAR_W-1:0]      chk_sym;
   logic                   chk_range_bad;
   logic                   chk_dup;
   logic [CMP_W-1:0]       radix_q;
   logic [CMP_W-1:0]       trial;
   logic                   q_bit;
   logic [CMP_W-1:0]       rem_next;
   logic [VALUE_W-1:0]     mag_shift;
   logic                   last_bit;
   logic [DIGIT_CNT_W-1:0] nd_dec;
   logic [DIGIT_W-1:0]     emit_digit_val;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_low_ff     <= '0;
         sym_high_ff    <= '0;
         radix_count_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_SYMBOLS_LOW:  sym_low_ff     <= csr_wdata;
            REG_SYMBOLS_HIGH: sym_high_ff    <= csr_wdata;
            REG_RADIX_COUNT:  radix_count_ff <= csr_wdata[RADIX_REG_W-1:0];
            default:          ;
         endcase
      end
   end

   // symbol view of the alphabet words
   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         if (k < SYM_PER_WORD) begin
            sym[k] = sym_low_ff[CHAR_W*k +: CHAR_W];
         end else begin
            sym[k] = sym_high_ff[CHAR_W*(k-SYM_PER_WORD) +: CHAR_W];
         end
      end
   end

   // alphabet check, one symbol per cycle against all earlier symbols
   assign radix_q = radix_count_ff[CMP_W-1:0];
   assign chk_sym = sym[chk_idx_ff];
   assign chk_range_bad = (chk_sym <= SPACE_LIMIT) || (chk_sym >= DEL_CODE) ||
                          (chk_sym == PLUS_CODE) || (chk_sym == MINUS_CODE);

   always_comb begin
      chk_dup = 1'b0;
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         if ((DIGIT_W'(j) < chk_idx_ff) && (sym[j] == chk_sym)) begin
            chk_dup = 1'b1;
         end
      end
   end

   // restoring division step, one quotient bit per cycle
   assign trial     = {rem_ff, mag_ff[VALUE_W-1]};
   assign q_bit     = (trial >= radix_q);
   assign rem_next  = q_bit ? (trial - radix_q) : trial;
   assign mag_shift = {mag_ff[VALUE_W-2:0], q_bit};
   assign last_bit  = &bit_cnt_ff;
   assign nd_dec    = nd_ff - DIGIT_CNT_W'(1);

   // next state of the conversion registers
   always_comb begin
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      nd_in      = nd_ff;
      chk_idx_in = chk_idx_ff;
      digit_we   = 1'b0;
      digit_in   = rem_next[DIGIT_W-1:0];
      if (cmd.load) begin
         neg_in     = req_value[VALUE_W-1];
         mag_in     = req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                           : VALUE_W'(req_value);
         rem_in     = '0;
         bit_cnt_in = '0;
         nd_in      = '0;
         chk_idx_in = '0;
      end else if (cmd.check_step) begin
         chk_idx_in = chk_idx_ff + DIGIT_W'(1);
      end else if (cmd.div_step) begin
         mag_in     = mag_shift;
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         if (last_bit) begin
            digit_we = 1'b1;
            rem_in   = '0;
            nd_in    = nd_ff + DIGIT_CNT_W'(1);
         end else begin
            rem_in   = rem_next[DIGIT_W-1:0];
         end
      end else if (cmd.emit_digit) begin
         nd_in = nd_dec;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      nd_ff      <= nd_in;
      chk_idx_ff <= chk_idx_in;
   end

   // digit buffer, written at the digit count, read back from the top down
   always_ff @(posedge clock) begin
      if (digit_we) begin
         digits_ff[nd_ff[DIGIT_IDX_W-1:0]] <= digit_in;
      end
   end

   assign emit_digit_val = digits_ff[nd_dec[DIGIT_IDX_W-1:0]];

   // output register, one character per strobe
   always_comb begin
      rsp_valid_in = cmd.emit_sign || cmd.emit_digit;
      rsp_char_in  = MINUS_CODE;
      rsp_last_in  = 1'b0;
      if (cmd.emit_digit) begin
         rsp_char_in = sym[emit_digit_val];
         rsp_last_in = (nd_ff == DIGIT_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // status to the controller
   assign status.radix_bad  = (radix_count_ff < RADIX_REG_W'(2)) ||
                              (radix_count_ff > RADIX_REG_W'(MAX_SYMBOLS));
   assign status.check_bad  = chk_range_bad || chk_dup;
   assign status.check_last = ((CMP_W'(chk_idx_ff) + CMP_W'(1)) == radix_q);
   assign status.conv_done  = last_bit &&
                              ((mag_shift == '0) || (nd_ff == DIGIT_CNT_W'(DIGIT_DEPTH - 1)));
   assign status.negative   = neg_ff;
   assign status.last_digit = (nd_ff == DIGIT_CNT_W'(1));

endmodule

`default_nettype wire

FILE: sv/sird_ctrl.sv
// controller: sequences check, division, sign and digit output per transaction
`default_nettype none

module sird_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire sird_pkg::sird_status_type status,
   output sird_pkg::sird_cmd_type         cmd
);
   import sird_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.radix_bad || status.check_bad) begin
               state_in = ST_IDLE;
            end else begin
               cmd.check_step = 1'b1;
               if (status.check_last) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.conv_done) begin
               state_in = status.negative ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_digit = 1'b1;
            if (status.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: sv/signed_integer_to_radix_digits_core.sv
// top level: signed integer to radix digit string converter
// operation: an alphabet check over the n symbols, then bit-serial division for each digit,
//   a minus sign if negative, then the digits, most significant first; each character is registered
// one transaction at a time: a new start is taken only when idle; the divider yields one
//   quotient bit per cycle
// an invalid radix count or alphabet ends the transaction after the check with no characters
// synchronous active-high reset clears the controller, output strobe and configuration registers to 0
`default_nettype none

module signed_integer_to_radix_digits_core #(
   parameter int MAX_SYMBOLS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [sird_pkg::VALUE_W-1:0] req_value,
   output logic                                     rsp_valid,
   output logic [sird_pkg::CHAR_W-1:0]              rsp_out_char,
   output logic                                     rsp_last,
   input  wire logic                                csr_write_en,
   input  wire logic [sird_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sird_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sird_pkg::*;

   sird_cmd_type    cmd;
   sird_status_type status;

   // sequencing
   sird_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // registers, divider and output
   sird_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_value    (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

FILE: sv/sird_checker.sv
// port-level checks on the converter, bound to the top level
`default_nettype none

module sird_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       rsp_valid,
   input wire logic [sird_pkg::CHAR_W-1:0] rsp_out_char,
   input wire logic                       rsp_last
);
   import sird_pkg::*;

   // an accepted transaction always makes the core busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // characters come only from work begun while busy
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("character strobe without a transaction in progress");

   // a final character is never followed at once by another
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("character strobe directly after the final character");

   // the minus sign is never final and is always followed by a digit
   a_sign_then_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_char == MINUS_CODE)) |-> (!rsp_last ##1 rsp_valid))
      else $error("minus sign not followed by a digit");

endmodule

bind signed_integer_to_radix_digits_core sird_checker u_sird_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_out_char (rsp_out_char),
   .rsp_last     (rsp_last)
);

`default_nettype wire
